### rtl/clne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clne_pkg;

   // Operation codes carried in the request.
   typedef enum logic [2:0] {
      FUNC_INIT      = 3'd0,
      FUNC_CLEAR     = 3'd1,
      FUNC_HOME      = 3'd2,
      FUNC_CURSOR    = 3'd3,
      FUNC_TEXT      = 3'd4,
      FUNC_RAW       = 3'd5,
      FUNC_CONTROL   = 3'd6,
      FUNC_BACKLIGHT = 3'd7
   } func_type;

   // One request item and one result item.
   typedef struct packed {
      func_type    func;
      logic [7:0]  ch;
      logic [7:0]  col;
      logic [7:0]  row;
   } req_type;

   typedef struct packed {
      logic [7:0]  expander_byte;
      logic        last;
   } rsp_type;

   // Register indexes on the control port.
   localparam logic [2:0] CSR_BACKLIGHT  = 3'd0;
   localparam logic [2:0] CSR_DISPLAY    = 3'd1;
   localparam logic [2:0] CSR_CURSOR     = 3'd2;
   localparam logic [2:0] CSR_BLINK      = 3'd3;
   localparam logic [2:0] CSR_LINE_COUNT = 3'd4;

   // LCD controller commands and characters.
   localparam logic [7:0] CMD_CLEAR          = 8'h01;
   localparam logic [7:0] CMD_HOME           = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MODE     = 8'h04;
   localparam logic [7:0] CMD_ENTRY_INC      = 8'h02;
   localparam logic [7:0] CMD_DISPLAY_CTRL   = 8'h08;
   localparam logic [7:0] CMD_FUNCTION_SET   = 8'h20;
   localparam logic [7:0] CMD_TWO_LINES      = 8'h08;
   localparam logic [7:0] CMD_DDRAM_ADDR     = 8'h80;
   localparam logic [7:0] WAKE_NIBBLE        = 8'h30;
   localparam logic [7:0] FOURBIT_NIBBLE     = 8'h20;
   localparam logic [7:0] CHAR_NUL           = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE       = 8'h0A;

   localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

   // Microcode: what a step emits and where its byte value comes from.
   typedef enum logic [1:0] {
      K_BYTE,     // one raw port byte
      K_NIB,      // one raw nibble, three port bytes
      K_FULL,     // one LCD byte, six port bytes
      K_BRANCH    // text dispatch, no output
   } kind_type;

   typedef enum logic [3:0] {
      S_ZERO,
      S_WAKE,
      S_FOURBIT,
      S_FUNCSET,
      S_CONTROL,
      S_ENTRY,
      S_CLEAR,
      S_HOME,
      S_CURSOR,
      S_DATA
   } src_type;

   typedef struct packed {
      kind_type  kind;
      src_type   src;
      logic      rs;
      logic      done;
   } uword_type;

   localparam int       STEPS = 16;
   localparam int       PC_W  = $clog2(STEPS);

   localparam logic [PC_W-1:0] STEP_INIT      = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_HOME      = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_CLEAR     = PC_W'(10);
   localparam logic [PC_W-1:0] STEP_CURSOR    = PC_W'(11);
   localparam logic [PC_W-1:0] STEP_TEXT      = PC_W'(12);
   localparam logic [PC_W-1:0] STEP_DATA      = PC_W'(13);
   localparam logic [PC_W-1:0] STEP_CONTROL   = PC_W'(14);
   localparam logic [PC_W-1:0] STEP_BACKLIGHT = PC_W'(15);

   // Program store. Init runs straight from step 0 through home.
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         4'd0:    w = '{K_BYTE,   S_ZERO,    1'b0, 1'b0};
         4'd1:    w = '{K_NIB,    S_WAKE,    1'b0, 1'b0};
         4'd2:    w = '{K_NIB,    S_WAKE,    1'b0, 1'b0};
         4'd3:    w = '{K_NIB,    S_WAKE,    1'b0, 1'b0};
         4'd4:    w = '{K_NIB,    S_FOURBIT, 1'b0, 1'b0};
         4'd5:    w = '{K_FULL,   S_FUNCSET, 1'b0, 1'b0};
         4'd6:    w = '{K_FULL,   S_CONTROL, 1'b0, 1'b0};
         4'd7:    w = '{K_FULL,   S_ENTRY,   1'b0, 1'b0};
         4'd8:    w = '{K_FULL,   S_CLEAR,   1'b0, 1'b0};
         4'd9:    w = '{K_FULL,   S_HOME,    1'b0, 1'b1};
         4'd10:   w = '{K_FULL,   S_CLEAR,   1'b0, 1'b1};
         4'd11:   w = '{K_FULL,   S_CURSOR,  1'b0, 1'b1};
         4'd12:   w = '{K_BRANCH, S_ZERO,    1'b0, 1'b0};
         4'd13:   w = '{K_FULL,   S_DATA,    1'b1, 1'b1};
         4'd14:   w = '{K_FULL,   S_CONTROL, 1'b0, 1'b1};
         4'd15:   w = '{K_FULL,   S_ZERO,    1'b0, 1'b1};
         default: w = '{K_FULL,   S_ZERO,    1'b0, 1'b1};
      endcase
      return w;
   endfunction

   // Entry step of each operation.
   function automatic logic [PC_W-1:0] entry_step(input func_type f);
      logic [PC_W-1:0] s;
      case (f)
         FUNC_INIT:    s = STEP_INIT;
         FUNC_CLEAR:   s = STEP_CLEAR;
         FUNC_HOME:    s = STEP_HOME;
         FUNC_CURSOR:  s = STEP_CURSOR;
         FUNC_TEXT:    s = STEP_TEXT;
         FUNC_RAW:     s = STEP_DATA;
         FUNC_CONTROL: s = STEP_CONTROL;
         default:      s = STEP_BACKLIGHT;
      endcase
      return s;
   endfunction

   // Row modulo the effective line count (zero counts as one, above four as four).
   // Modulo three folds base-4 digits, since four is one modulo three.
   function automatic logic [1:0] line_of(input logic [7:0] r, input logic [2:0] lines);
      logic [3:0] s;
      logic [2:0] t;
      logic [1:0] m3;
      logic [1:0] l;
      s = {2'b00, r[1:0]} + {2'b00, r[3:2]} + {2'b00, r[5:4]} + {2'b00, r[7:6]};
      t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
      if (t >= 3'd6) begin
         m3 = 2'd0;
      end else if (t >= 3'd3) begin
         m3 = 2'(t - 3'd3);
      end else begin
         m3 = t[1:0];
      end
      case (lines)
         3'd0, 3'd1: l = 2'd0;
         3'd2:       l = {1'b0, r[0]};
         3'd3:       l = m3;
         default:    l = r[1:0];
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

### rtl/char_lcd_nibble_expander_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// A request goes into the sequencer state; each port byte is registered on its way out.
// Text first passes a dispatch step. One port byte per cycle while the receiver does not
// stall; an LCD byte is six port bytes, init is 43 port bytes, and a NUL text gives none.
// The rate is set by the microcode sequencer, which works on one request at a time.
// Reset (synchronous, active high) idles the sequencer, empties the output register,
// clears the current line and loads the register defaults.
module char_lcd_nibble_expander_encoder
   import clne_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // Control state.
   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [2:0]       sub_ff, sub_in;
   logic [1:0]       line_ff, line_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [7:0]       ch_ff, ch_in;
   logic [7:0]       col_ff, col_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Configuration registers.
   logic             bl_ff, disp_ff, curs_ff, blink_ff;
   logic [2:0]       lines_ff;

   uword_type        word;
   logic             req_accept;
   logic             adv;
   logic             newline;
   logic [7:0]       row_sel;
   logic [7:0]       value;
   logic [2:0]       sub_end;
   logic [3:0]       nibble;
   logic             en_bit;
   logic             full;
   logic             csr_write;
   logic [2:0]       csr_index;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign word       = ucode_rom(pc_ff);
   assign full       = (word.kind == K_FULL);

   // A text newline moves to column zero of the next line.
   assign newline = (req_data.func == FUNC_TEXT) && (req_data.ch == CHAR_NEWLINE);
   assign row_sel = newline ? 8'({line_ff} + 3'd1) : req_data.row;

   // Byte value selected by the current step.
   always_comb begin
      case (word.src)
         S_ZERO:    value = 8'h00;
         S_WAKE:    value = WAKE_NIBBLE;
         S_FOURBIT: value = FOURBIT_NIBBLE;
         S_FUNCSET: value = CMD_FUNCTION_SET | ((lines_ff > 3'd1) ? CMD_TWO_LINES : 8'h00);
         S_CONTROL: value = CMD_DISPLAY_CTRL | {5'd0, disp_ff, curs_ff, blink_ff};
         S_ENTRY:   value = CMD_ENTRY_MODE | CMD_ENTRY_INC;
         S_CLEAR:   value = CMD_CLEAR;
         S_HOME:    value = CMD_HOME;
         S_CURSOR:  value = CMD_DDRAM_ADDR | (col_ff + ROW_OFFSET[line_ff]);
         S_DATA:    value = ch_ff;
         default:   value = 8'h00;
      endcase
   end

   // Port byte formed from the value and the position within the step.
   always_comb begin
      case (word.kind)
         K_BYTE:  sub_end = 3'd0;
         K_NIB:   sub_end = 3'd2;
         default: sub_end = 3'd5;
      endcase
      nibble = (full && sub_ff >= 3'd3) ? value[3:0] : value[7:4];
      en_bit = (sub_ff == 3'd1) || (sub_ff == 3'd4);
   end

   // Sequencer next state.
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      sub_in       = sub_ff;
      line_in      = line_ff;
      ch_in        = ch_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (req_accept) begin
         busy_in = 1'b1;
         pc_in   = entry_step(req_data.func);
         sub_in  = 3'd0;
         ch_in   = req_data.ch;
         col_in  = newline ? 8'h00 : req_data.col;
         if (req_data.func == FUNC_CURSOR || newline) begin
            line_in = line_of(row_sel, lines_ff);
         end
      end else if (busy_ff) begin
         if (word.kind == K_BRANCH) begin
            // Text dispatch: NUL ends quietly, newline sets the cursor.
            if (ch_ff == CHAR_NUL) begin
               busy_in = 1'b0;
            end else if (ch_ff == CHAR_NEWLINE) begin
               pc_in = STEP_CURSOR;
            end else begin
               pc_in = STEP_DATA;
            end
         end else if (adv) begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.expander_byte = {nibble, bl_ff && full, en_bit, 1'b0, word.rs && full};
            rsp_data_in.last          = word.done && (sub_ff == sub_end);
            if (sub_ff == sub_end) begin
               sub_in = 3'd0;
               if (word.done) begin
                  busy_in = 1'b0;
               end else begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= STEP_INIT;
         sub_ff       <= 3'd0;
         line_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         sub_ff       <= sub_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Control port: writes on the access cycle, reads return the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_ff    <= 1'b0;
         disp_ff  <= 1'b1;
         curs_ff  <= 1'b1;
         blink_ff <= 1'b1;
         lines_ff <= 3'd2;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BACKLIGHT:  bl_ff    <= csr_pwdata[0];
            CSR_DISPLAY:    disp_ff  <= csr_pwdata[0];
            CSR_CURSOR:     curs_ff  <= csr_pwdata[0];
            CSR_BLINK:      blink_ff <= csr_pwdata[0];
            CSR_LINE_COUNT: lines_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_BACKLIGHT:  csr_prdata = {31'd0, bl_ff};
         CSR_DISPLAY:    csr_prdata = {31'd0, disp_ff};
         CSR_CURSOR:     csr_prdata = {31'd0, curs_ff};
         CSR_BLINK:      csr_prdata = {31'd0, blink_ff};
         CSR_LINE_COUNT: csr_prdata = {29'd0, lines_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

`ifndef SYNTHESIS
   // A stalled port byte stays in place until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled port byte changed or dropped");

   // The position within a step rests at zero between requests.
   a_sub_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> sub_ff == 3'd0)
      else $error("step position not at zero while idle");

   // The current line only moves when a request is taken.
   a_line_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(line_ff))
      else $error("current line changed without a request");

   // Outside a full LCD byte, the step position stays within the three bytes of a raw nibble.
   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && word.kind != K_FULL |-> sub_ff <= 3'd2)
      else $error("step position beyond a raw step");
`endif

endmodule

`default_nettype wire

### dv/char_lcd_port_byte_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the LCD nibble encoder,
// predicts the port bytes of every accepted request and compares them in order.
module char_lcd_port_byte_checker
   import clne_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req_data,

   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,

   output int               failures,
   output int               pending
);

   localparam logic [7:0] PORT_SELECT    = 8'h01;
   localparam logic [7:0] PORT_ENABLE    = 8'h04;
   localparam logic [7:0] PORT_BACKLIGHT = 8'h08;

   // Shadow copy of the registers and the line state.
   logic       backlight_on;
   logic       display_on;
   logic       cursor_on;
   logic       blink_on;
   logic [2:0] line_count;
   logic [1:0] current_line;

   // Port bytes still owed by the block, oldest first.
   rsp_type    port_bytes_due [$];
   // Port bytes of the request being encoded.
   logic [7:0] op_bytes [$];

   // A line count of zero acts as one line, anything above four as four.
   function automatic int lines_in_use(input logic [2:0] count);
      if (count == 3'd0) begin
         return 1;
      end else if (count > 3'd4) begin
         return 4;
      end
      return int'(count);
   endfunction

   function automatic logic [7:0] row_base(input logic [1:0] line);
      case (line)
         2'd0:    return 8'h00;
         2'd1:    return 8'h40;
         2'd2:    return 8'h14;
         default: return 8'h54;
      endcase
   endfunction

   function automatic logic [7:0] control_command();
      return CMD_DISPLAY_CTRL | {5'b00000, display_on, cursor_on, blink_on};
   endfunction

   // One nibble strobes enable high and low around its value.
   task automatic add_nibble(input logic [7:0] v);
      op_bytes.push_back(v);
      op_bytes.push_back(v | PORT_ENABLE);
      op_bytes.push_back(v & ~PORT_ENABLE);
   endtask

   // A full LCD byte goes out high nibble first, with select and backlight bits.
   task automatic add_lcd_byte(input logic [7:0] value, input logic rs);
      logic [7:0] mode;
      mode = (rs ? PORT_SELECT : 8'h00) | (backlight_on ? PORT_BACKLIGHT : 8'h00);
      add_nibble({value[7:4], 4'h0} | mode);
      add_nibble({value[3:0], 4'h0} | mode);
   endtask

   // The row wraps over the lines in use and the address keeps its low 8 bits.
   task automatic add_cursor_move(input logic [7:0] col, input int row);
      int         line;
      logic [7:0] addr;
      line = row % lines_in_use(line_count);
      current_line = line[1:0];
      addr = col + row_base(current_line);
      add_lcd_byte(CMD_DDRAM_ADDR | addr, 1'b0);
   endtask

   task automatic encode_operation(input req_type r);
      rsp_type item;
      op_bytes.delete();
      case (r.func)
         FUNC_INIT: begin
            op_bytes.push_back(8'h00);
            add_nibble(WAKE_NIBBLE);
            add_nibble(WAKE_NIBBLE);
            add_nibble(WAKE_NIBBLE);
            add_nibble(FOURBIT_NIBBLE);
            add_lcd_byte(CMD_FUNCTION_SET |
                         ((lines_in_use(line_count) > 1) ? CMD_TWO_LINES : 8'h00), 1'b0);
            add_lcd_byte(control_command(), 1'b0);
            add_lcd_byte(CMD_ENTRY_MODE | CMD_ENTRY_INC, 1'b0);
            add_lcd_byte(CMD_CLEAR, 1'b0);
            add_lcd_byte(CMD_HOME, 1'b0);
         end
         FUNC_CLEAR: begin
            add_lcd_byte(CMD_CLEAR, 1'b0);
         end
         FUNC_HOME: begin
            add_lcd_byte(CMD_HOME, 1'b0);
         end
         FUNC_CURSOR: begin
            add_cursor_move(r.col, int'(r.row));
         end
         FUNC_TEXT: begin
            // NUL sends nothing; newline moves to the start of the next line.
            if (r.ch == CHAR_NEWLINE) begin
               add_cursor_move(8'h00, int'(current_line) + 1);
            end else if (r.ch != CHAR_NUL) begin
               add_lcd_byte(r.ch, 1'b1);
            end
         end
         FUNC_RAW: begin
            add_lcd_byte(r.ch, 1'b1);
         end
         FUNC_CONTROL: begin
            add_lcd_byte(control_command(), 1'b0);
         end
         default: begin
            add_lcd_byte(8'h00, 1'b0);
         end
      endcase
      foreach (op_bytes[i]) begin
         item.expander_byte = op_bytes[i];
         item.last = (i == op_bytes.size() - 1);
         port_bytes_due.push_back(item);
      end
   endtask

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         backlight_on = 1'b0;
         display_on = 1'b1;
         cursor_on = 1'b1;
         blink_on = 1'b1;
         line_count = 3'd2;
         current_line = 2'd0;
         port_bytes_due.delete();
      end else begin
         // Register writes land on the access cycle.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               CSR_BACKLIGHT:  backlight_on = csr_pwdata[0];
               CSR_DISPLAY:    display_on = csr_pwdata[0];
               CSR_CURSOR:     cursor_on = csr_pwdata[0];
               CSR_BLINK:      blink_on = csr_pwdata[0];
               CSR_LINE_COUNT: line_count = csr_pwdata[2:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            encode_operation(req_data);
         end

         // Compare each accepted port byte with the oldest one owed.
         if (rsp_valid && !rsp_stall) begin
            if (port_bytes_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected port byte, expected none, actual %h last %b",
                        $time, rsp_data.expander_byte, rsp_data.last);
            end else begin
               want = port_bytes_due.pop_front();
               if (rsp_data.expander_byte !== want.expander_byte) begin
                  failures++;
                  $display("%0t: port byte mismatch, expected %h, actual %h",
                           $time, want.expander_byte, rsp_data.expander_byte);
               end
               if (rsp_data.last !== want.last) begin
                  failures++;
                  $display("%0t: last flag mismatch, expected %b, actual %b",
                           $time, want.last, rsp_data.last);
               end
            end
         end
      end
      pending = port_bytes_due.size();
   end

endmodule

### dv/char_lcd_nibble_expander_encoder_test.sv
`timescale 1ns / 1ps

module char_lcd_nibble_expander_encoder_test;
   import clne_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   char_lcd_nibble_expander_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   char_lcd_port_byte_checker port_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, one decision per cycle.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic req_type make_request(input func_type f, input logic [7:0] ch,
                                            input logic [7:0] col, input logic [7:0] row);
      req_type r;
      r.func = f;
      r.ch = ch;
      r.col = col;
      r.row = row;
      return r;
   endfunction

   // Init is long, so it is drawn less often; text leans on NUL and newline.
   function automatic req_type random_request();
      req_type    r;
      logic [2:0] code;
      code = 3'($urandom_range(7));
      if (code == FUNC_INIT && $urandom_range(2) != 0) begin
         code = FUNC_TEXT;
      end
      r.func = func_type'(code);
      r.ch = 8'($urandom);
      if (r.func == FUNC_TEXT) begin
         case ($urandom_range(4))
            0:       r.ch = CHAR_NUL;
            1:       r.ch = CHAR_NEWLINE;
            default: ;
         endcase
      end
      r.col = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(39));
      r.row = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      return r;
   endfunction

   // Entered and left just after a falling edge; valid stays high if no gap follows.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Wait for every owed port byte, then let a NUL still in dispatch finish.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [2:0] index, input logic [2:0] value);
      req_valid = 1'b0;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = ($urandom & ~32'h7) | {29'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic write_settings(input logic bl, input logic disp, input logic cur,
                                 input logic blink, input logic [2:0] lines);
      csr_write(CSR_BACKLIGHT, {2'b00, bl});
      csr_write(CSR_DISPLAY, {2'b00, disp});
      csr_write(CSR_CURSOR, {2'b00, cur});
      csr_write(CSR_BLINK, {2'b00, blink});
      csr_write(CSR_LINE_COUNT, lines);
   endtask

   initial begin : stimulus
      int phase;
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Every operation at the reset defaults, two lines.
      send_request(make_request(FUNC_INIT, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(FUNC_HOME, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_CURSOR, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_CURSOR, 8'h00, 8'hFF, 8'hFF));
      send_request(make_request(FUNC_TEXT, 8'h41, 8'h00, 8'h00));
      send_request(make_request(FUNC_TEXT, CHAR_NUL, 8'hFF, 8'hFF));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_TEXT, 8'hFF, 8'h00, 8'h00));
      send_request(make_request(FUNC_RAW, CHAR_NUL, 8'h00, 8'h00));
      send_request(make_request(FUNC_RAW, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_RAW, 8'hFF, 8'h00, 8'h00));
      send_request(make_request(FUNC_CONTROL, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_BACKLIGHT, 8'h00, 8'h00, 8'h00));

      // Backlight on, all flags off, four lines: newline wraps past the last row.
      wait_idle();
      write_settings(1'b1, 1'b0, 1'b0, 1'b0, 3'd4);
      send_request(make_request(FUNC_INIT, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_CURSOR, 8'h00, 8'h2C, 8'h06));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_CONTROL, 8'h00, 8'h00, 8'h00));
      send_request(make_request(FUNC_BACKLIGHT, 8'h00, 8'h00, 8'h00));

      // Line count zero acts as one line.
      wait_idle();
      csr_write(CSR_LINE_COUNT, 3'd0);
      send_request(make_request(FUNC_CURSOR, 8'h00, 8'h10, 8'hFF));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));

      // Line count above four acts as four; writes past the register list are dropped.
      wait_idle();
      csr_write(CSR_LINE_COUNT, 3'd7);
      csr_write(3'd5, 3'd7);
      csr_write(3'd7, 3'd7);
      send_request(make_request(FUNC_CURSOR, 8'h00, 8'hFF, 8'hFF));
      send_request(make_request(FUNC_TEXT, CHAR_NEWLINE, 8'h00, 8'h00));
      send_request(make_request(FUNC_CONTROL, 8'h00, 8'h00, 8'h00));

      // Random phases, each with its own settings and idling pattern.
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: write_settings(1'b1, 1'b1, 1'b0, 1'b1, 3'd4);
            1: write_settings(1'b0, 1'b0, 1'b1, 1'b0, 3'd1);
            2: write_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)), 3'd3);
            default: write_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    3'($urandom_range(7)));
         endcase
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 61;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 61;
            end
            default: begin
               sender_idle_pct = 18;
               receiver_stall_pct = 18;
            end
         endcase
         for (k = 0; k < 96; k++) begin
            // Hold the sender back now and then until the block has drained.
            if (k == 48 || $urandom_range(39) == 0) begin
               wait_idle();
            end
            send_request(random_request());
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a block that hangs.
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
